@@ design/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/gtam_pkg.sv @@
package gtam_pkg;

   localparam int TEX_WIDTH  = 256;
   localparam int TEX_HEIGHT = 128;
   localparam int HALF_TEX   = TEX_WIDTH / 2;

   localparam longint          Q_ONE  = 64'sd1073741824;
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   localparam logic [1:0] CSR_ROTATION = 2'd0;
   localparam logic [1:0] CSR_CENTER_X = 2'd1;
   localparam logic [1:0] CSR_CENTER_Y = 2'd2;

   typedef struct packed {
      logic       in_span;
      logic       night;
      logic       neg;
      logic [6:0] tex_row;
      logic [9:0] screen_x;
      logic [9:0] screen_y;
   } side_type;

   // shift-subtract divide, elaboration only
   function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      int              b;
      quo = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // cos(pi*m/d) in Q30, truncated series
   function automatic longint cos_frac(int unsigned m_in, int unsigned d);
      longint unsigned a;
      longint unsigned a2;
      longint unsigned term;
      longint          sum;
      logic            neg;
      int unsigned     m;
      int unsigned     n;
      m   = m_in;
      neg = 1'b0;
      if (m == 0) return Q_ONE;
      if (m >= d) return -Q_ONE;
      if (2 * m == d) return 64'sd0;
      if (3 * m == d) return Q_ONE / 2;
      if (3 * m == 2 * d) return -(Q_ONE / 2);
      if (2 * m > d) begin
         m   = d - m;
         neg = 1'b1;
      end
      a    = udiv64(PI_Q30 * 64'(m), 64'(d));
      a2   = (a * a) >> 30;
      term = 64'(Q_ONE);
      sum  = Q_ONE;
      for (n = 1; n <= 12; n++) begin
         term = udiv64((term * a2) >> 30, 64'((2 * n - 1) * (2 * n)));
         if (n[0]) sum = sum - longint'(term);
         else      sum = sum + longint'(term);
      end
      return neg ? -sum : sum;
   endfunction

endpackage

@@ design/gtam_row.sv @@
module gtam_row #(
   parameter int GLOBE_RADIUS = 64,
   parameter int HALF_ARC     = 512,
   parameter int NUM_W        = 18
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [7:0]   pixel_y,
   input  logic signed [7:0]   pixel_x,
   input  logic [9:0]          center_x,
   input  logic [9:0]          center_y,
   output logic                out_valid,
   output logic [NUM_W-1:0]    out_num,
   output logic [7:0]          out_den,
   output gtam_pkg::side_type  out_side
);
   import gtam_pkg::*;

   localparam int ROWS = 2 * GLOBE_RADIUS;
   localparam int RW   = $clog2(ROWS);
   localparam logic signed [9:0] Y_MIN = 10'(-GLOBE_RADIUS);
   localparam logic signed [9:0] Y_MAX = 10'(GLOBE_RADIUS);

   function automatic logic [ROWS*8-1:0] build_xr_tab();
      logic [ROWS*8-1:0] tab;
      longint            n;
      longint            xr;
      longint            y;
      int                i;
      tab = '0;
      for (i = 0; i < ROWS; i++) begin
         y  = longint'(i) - longint'(GLOBE_RADIUS);
         n  = longint'(GLOBE_RADIUS) * longint'(GLOBE_RADIUS) - y * y;
         xr = 0;
         while ((xr + 1) * (xr + 1) - (xr + 1) + 1 <= n) xr++;
         if (xr == 0) xr = 1;
         tab[i*8 +: 8] = 8'(xr);
      end
      return tab;
   endfunction

   function automatic logic [ROWS*7-1:0] build_line_tab();
      logic [ROWS*7-1:0] tab;
      longint            ncos [TEX_HEIGHT+1];
      longint            s;
      int                i;
      int                k;
      int                v;
      tab = '0;
      for (k = 0; k <= TEX_HEIGHT; k++) ncos[k] = -cos_frac(k, TEX_HEIGHT);
      for (i = 0; i < ROWS; i++) begin
         s = (longint'(i) - longint'(GLOBE_RADIUS)) * Q_ONE;
         v = 0;
         for (k = 1; k < TEX_HEIGHT; k++)
            if (s >= ncos[k] * longint'(GLOBE_RADIUS)) v = k;
         tab[i*7 +: 7] = 7'(v);
      end
      return tab;
   endfunction

   localparam logic [ROWS*8-1:0] XR_TAB   = build_xr_tab();
   localparam logic [ROWS*7-1:0] LINE_TAB = build_line_tab();

   logic signed [9:0] y_ext;
   logic signed [9:0] x_ext;
   logic [9:0]        row_sum;
   logic [RW-1:0]     row_idx;
   logic              row_ok;

   assign y_ext   = {{2{pixel_y[7]}}, pixel_y};
   assign x_ext   = {{2{pixel_x[7]}}, pixel_x};
   assign row_sum = $unsigned(y_ext) + 10'(GLOBE_RADIUS);
   assign row_idx = row_sum[RW-1:0];
   assign row_ok  = (y_ext >= Y_MIN) && (y_ext < Y_MAX);

   // stage A: row tables, screen coordinates
   logic              a_valid_ff;
   logic signed [7:0] a_x_ff;
   logic              a_yodd_ff;
   logic              a_row_ok_ff;
   logic [7:0]        a_xr_ff;
   logic [6:0]        a_line_ff;
   logic [9:0]        a_sx_ff;
   logic [9:0]        a_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff      <= pixel_x;
         a_yodd_ff   <= pixel_y[0];
         a_row_ok_ff <= row_ok;
         a_xr_ff     <= XR_TAB[row_idx*8 +: 8];
         a_line_ff   <= LINE_TAB[row_idx*7 +: 7];
         a_sx_ff     <= center_x + $unsigned(x_ext);
         a_sy_ff     <= center_y + $unsigned(y_ext);
      end
   end

   // stage B: span test, terminator bands, dividend
   logic signed [9:0] xa;
   logic signed [9:0] xr_s;
   logic [10:0]       xr7;
   logic [10:0]       xr9;
   logic [10:0]       xr10;
   logic signed [9:0] th7;
   logic signed [9:0] th8;
   logic signed [9:0] th9;
   logic signed [9:0] th10;
   logic              inside_v;
   logic              night_v;
   logic              xp;
   logic              neg_v;
   logic [7:0]        ax;
   logic [NUM_W-1:0]  num_in;
   side_type          side_in;

   assign xa   = {{2{a_x_ff[7]}}, a_x_ff};
   assign xr_s = {2'b00, a_xr_ff};
   assign xr7  = 11'(a_xr_ff) * 11'd7;
   assign xr9  = 11'(a_xr_ff) * 11'd9;
   assign xr10 = 11'(a_xr_ff) * 11'd10;
   assign th7  = {3'b000, xr7[10:4]};
   assign th8  = {3'b000, 7'(a_xr_ff[7:1])};
   assign th9  = {3'b000, xr9[10:4]};
   assign th10 = {3'b000, xr10[10:4]};
   assign xp   = a_x_ff[0];
   assign neg_v = a_x_ff[7];
   assign ax   = neg_v ? 8'(-a_x_ff) : 8'(a_x_ff);
   assign inside_v = a_row_ok_ff && (xa >= -xr_s) && (xa < xr_s);
   assign num_in = NUM_W'(ax) * NUM_W'(HALF_ARC);

   always_comb begin
      priority if (xa < th7) begin
         night_v = 1'b0;
      end else if (xa >= th10) begin
         night_v = 1'b1;
      end else if (xa < th8) begin
         night_v = !xp && !a_yodd_ff;
      end else if (xa < th9) begin
         night_v = (xp == a_yodd_ff);
      end else begin
         night_v = !(xp && a_yodd_ff);
      end
   end

   always_comb begin
      side_in.in_span  = inside_v;
      side_in.night    = inside_v && night_v;
      side_in.neg      = neg_v;
      side_in.tex_row  = inside_v ? a_line_ff : 7'd0;
      side_in.screen_x = a_sx_ff;
      side_in.screen_y = a_sy_ff;
   end

   logic             b_valid_ff;
   logic [NUM_W-1:0] b_num_ff;
   logic [7:0]       b_den_ff;
   side_type         b_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_num_ff  <= num_in;
         b_den_ff  <= a_xr_ff;
         b_side_ff <= side_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_num   = b_num_ff;
   assign out_den   = b_den_ff;
   assign out_side  = b_side_ff;

endmodule

@@ design/gtam_div.sv @@
module gtam_div #(
   parameter int NUM_W = 18,
   parameter int QUO_W = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [NUM_W-1:0]    in_num,
   input  logic [7:0]          in_den,
   input  gtam_pkg::side_type  in_side,
   output logic                out_valid,
   output logic [QUO_W-1:0]    out_quo,
   output gtam_pkg::side_type  out_side
);
   import gtam_pkg::*;

   // one quotient bit per stage, MSB first
   logic [NUM_W-1:0] rem_ff  [QUO_W];
   logic [QUO_W-1:0] quo_ff  [QUO_W];
   logic [7:0]       den_ff  [QUO_W];
   side_type         side_ff [QUO_W];
   logic [QUO_W-1:0] valid_ff;

   logic [NUM_W-1:0] rem_src  [QUO_W];
   logic [QUO_W-1:0] quo_src  [QUO_W];
   logic [7:0]       den_src  [QUO_W];
   side_type         side_src [QUO_W];
   logic [QUO_W-1:0] valid_src;
   logic [NUM_W-1:0] rem_in   [QUO_W];
   logic [QUO_W-1:0] quo_in   [QUO_W];

   always_comb begin
      rem_src[0]   = in_num;
      quo_src[0]   = '0;
      den_src[0]   = in_den;
      side_src[0]  = in_side;
      valid_src[0] = in_valid;
      for (int s = 1; s < QUO_W; s++) begin
         rem_src[s]   = rem_ff[s-1];
         quo_src[s]   = quo_ff[s-1];
         den_src[s]   = den_ff[s-1];
         side_src[s]  = side_ff[s-1];
         valid_src[s] = valid_ff[s-1];
      end
   end

   always_comb begin
      logic [NUM_W-1:0] trial;
      for (int s = 0; s < QUO_W; s++) begin
         trial = NUM_W'(den_src[s]) << (QUO_W - 1 - s);
         if (rem_src[s] >= trial) begin
            rem_in[s] = rem_src[s] - trial;
            quo_in[s] = quo_src[s] | (QUO_W'(1) << (QUO_W - 1 - s));
         end else begin
            rem_in[s] = rem_src[s];
            quo_in[s] = quo_src[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_src;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < QUO_W; s++) begin
            rem_ff[s]  <= rem_in[s];
            quo_ff[s]  <= quo_in[s];
            den_ff[s]  <= den_src[s];
            side_ff[s] <= side_src[s];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

@@ design/gtam_col.sv @@
module gtam_col #(
   parameter int ARC_SIZE = 1024,
   parameter int QUO_W    = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [QUO_W-1:0]    in_quo,
   input  gtam_pkg::side_type  in_side,
   input  logic [7:0]          rotation,
   output logic                out_valid,
   output logic                out_inside_res,
   output logic [9:0]          out_screen_x,
   output logic [9:0]          out_screen_y,
   output logic                out_use_night,
   output logic [6:0]          out_tex_row,
   output logic [7:0]          out_tex_col
);
   import gtam_pkg::*;

   localparam int HALF  = ARC_SIZE / 2;
   localparam int IDX_W = $clog2(ARC_SIZE);

   function automatic logic [ARC_SIZE*8-1:0] build_col_tab();
      logic [ARC_SIZE*8-1:0] tab;
      longint                ncos [HALF_TEX+1];
      longint                s;
      int                    i;
      int                    k;
      int                    u;
      tab = '0;
      for (k = 0; k <= HALF_TEX; k++) ncos[k] = -cos_frac(k, HALF_TEX);
      for (i = 0; i < ARC_SIZE; i++) begin
         s = (longint'(i) - longint'(HALF)) * Q_ONE;
         u = 0;
         for (k = 1; k <= HALF_TEX; k++)
            if (s >= ncos[k] * longint'(HALF)) u = k;
         tab[i*8 +: 8] = 8'(u);
      end
      return tab;
   endfunction

   localparam logic [ARC_SIZE*8-1:0] COL_TAB = build_col_tab();

   // stage C: table index
   logic [IDX_W:0]   idx_sum;
   logic [IDX_W-1:0] idx_in;

   assign idx_sum = in_side.neg ? ((IDX_W+1)'(HALF) - (IDX_W+1)'(in_quo))
                                : ((IDX_W+1)'(HALF) + (IDX_W+1)'(in_quo));
   assign idx_in  = (idx_sum > (IDX_W+1)'(ARC_SIZE - 1)) ? IDX_W'(ARC_SIZE - 1)
                                                          : idx_sum[IDX_W-1:0];

   logic             c_valid_ff;
   logic [IDX_W-1:0] c_idx_ff;
   side_type         c_side_ff;

   // stage D: arcsine ROM, registered read
   logic             d_valid_ff;
   logic [7:0]       d_u_ff;
   side_type         d_side_ff;

   // stage E: output register
   logic             e_valid_ff;
   side_type         e_side_ff;
   logic [7:0]       e_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= in_valid;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_idx_ff  <= idx_in;
         c_side_ff <= in_side;
         d_u_ff    <= COL_TAB[c_idx_ff*8 +: 8];
         d_side_ff <= c_side_ff;
         e_side_ff <= d_side_ff;
         e_col_ff  <= d_side_ff.in_span ? (d_u_ff + rotation + 8'(HALF_TEX)) : 8'd0;
      end
   end

   assign out_valid      = e_valid_ff;
   assign out_inside_res = e_side_ff.in_span;
   assign out_screen_x   = e_side_ff.screen_x;
   assign out_screen_y   = e_side_ff.screen_y;
   assign out_use_night  = e_side_ff.night;
   assign out_tex_row    = e_side_ff.tex_row;
   assign out_tex_col    = e_col_ff;

endmodule

@@ design/globe_texture_address_mapper_top.sv @@
// Globe texture address mapper. Takes one pixel offset from the globe center per word and
// returns its screen position, whether it falls inside the row span, the day/night texture
// choice with dithered terminator bands, the texture line and the rotated texture column.
// Fully pipelined: a new word every clock unless rsp_stall holds the pipeline; most of the
// depth comes from the column-index divider, which resolves one quotient bit per stage. All
// tables are constants built at elaboration. A one-word skid register on the input keeps
// req_stall registered. Write the csr registers only while idle.
module globe_texture_address_mapper_top #(
   parameter int GLOBE_RADIUS   = 64,
   parameter int ARC_TABLE_SIZE = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic signed [7:0] req_pixel_y,
   input  logic signed [7:0] req_pixel_x,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_inside_res,
   output logic [9:0]        rsp_screen_x,
   output logic [9:0]        rsp_screen_y,
   output logic              rsp_use_night,
   output logic [6:0]        rsp_tex_row,
   output logic [7:0]        rsp_tex_col,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [9:0]        csr_data
);
   import gtam_pkg::*;

   localparam int HALF_ARC = ARC_TABLE_SIZE / 2;
   localparam int QUO_W    = $clog2(HALF_ARC + 1);
   localparam int NUM_W    = 8 + QUO_W;

   // control registers
   logic [7:0] rotation_ff;
   logic [9:0] center_x_ff;
   logic [9:0] center_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= 8'd0;
         center_x_ff <= 10'd160;
         center_y_ff <= 10'd120;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROTATION: rotation_ff <= csr_data[7:0];
            CSR_CENTER_X: center_x_ff <= csr_data;
            CSR_CENTER_Y: center_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline advance and input skid
   logic              en;
   logic              accept;
   logic              skid_valid_ff;
   logic              skid_valid_in;
   logic signed [7:0] skid_y_ff;
   logic signed [7:0] skid_x_ff;
   logic              src_valid;
   logic signed [7:0] src_y;
   logic signed [7:0] src_x;

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign src_valid = skid_valid_ff || req_valid;
   assign src_y     = skid_valid_ff ? skid_y_ff : req_pixel_y;
   assign src_x     = skid_valid_ff ? skid_x_ff : req_pixel_x;

   always_comb begin
      if (en) begin
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_valid_in = 1'b1;
      end else begin
         skid_valid_in = skid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && accept) begin
         skid_y_ff <= req_pixel_y;
         skid_x_ff <= req_pixel_x;
      end
   end

   logic             row_valid;
   logic [NUM_W-1:0] row_num;
   logic [7:0]       row_den;
   side_type         row_side;

   gtam_row #(
      .GLOBE_RADIUS (GLOBE_RADIUS),
      .HALF_ARC     (HALF_ARC),
      .NUM_W        (NUM_W)
   ) u_row (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (src_valid),
      .pixel_y   (src_y),
      .pixel_x   (src_x),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .out_valid (row_valid),
      .out_num   (row_num),
      .out_den   (row_den),
      .out_side  (row_side)
   );

   logic             div_valid;
   logic [QUO_W-1:0] div_quo;
   side_type         div_side;

   gtam_div #(
      .NUM_W (NUM_W),
      .QUO_W (QUO_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (row_valid),
      .in_num    (row_num),
      .in_den    (row_den),
      .in_side   (row_side),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   gtam_col #(
      .ARC_SIZE (ARC_TABLE_SIZE),
      .QUO_W    (QUO_W)
   ) u_col (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (div_valid),
      .in_quo         (div_quo),
      .in_side        (div_side),
      .rotation       (rotation_ff),
      .out_valid      (rsp_valid),
      .out_inside_res (rsp_inside_res),
      .out_screen_x   (rsp_screen_x),
      .out_screen_y   (rsp_screen_y),
      .out_use_night  (rsp_use_night),
      .out_tex_row    (rsp_tex_row),
      .out_tex_col    (rsp_tex_col)
   );

endmodule

@@ design/gtam_checker.sv @@
`include "assert_macros.svh"

module gtam_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_inside_res,
   input logic [9:0] rsp_screen_x,
   input logic [9:0] rsp_screen_y,
   input logic       rsp_use_night,
   input logic [6:0] rsp_tex_row,
   input logic [7:0] rsp_tex_col
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_inside_res) && $stable(rsp_screen_x) && $stable(rsp_screen_y) && $stable(rsp_use_night) && $stable(rsp_tex_row) && $stable(rsp_tex_col))

   `ASSERT_IMPLIES(a_outside_zero, clock, reset, rsp_valid && !rsp_inside_res, !rsp_use_night && rsp_tex_row == 7'd0 && rsp_tex_col == 8'd0)

   `ASSERT_IMPLIES(a_stall_cause, clock, reset, $rose(req_stall), $past(req_valid && rsp_valid && rsp_stall))

   `ASSERT_NEXT(a_stall_release, clock, reset, req_stall && !(rsp_valid && rsp_stall), !req_stall)

endmodule

bind globe_texture_address_mapper_top gtam_checker u_checker (.*);
